/* hw/rtl/double_ended_queue_unit_macros.svh */
// Assertion macros for the double-ended queue unit.
// Used by the control block; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on the rising edge, skipped while reset is asserted.
`define DEQU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deque check failed");
// Checked on every rising edge, reset included.
`define DEQU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("deque check failed during reset");
`else
`define DEQU_ASSERT(label, clk, rst_n, prop)
`define DEQU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hw/rtl/dequ_pkg.sv */
// Shared types and constants for the double-ended queue unit.
// No dependencies.
`timescale 1ns / 1ps
package dequ_pkg;

  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned COUNT_W        = 11;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_BACK  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]                 func;
    logic signed [VALUE_W-1:0]  push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  read_value;
    status_e                    status;
    logic [COUNT_W-1:0]         entry_count;
    logic                       is_empty;
  } out_word_t;

  // Per-row command: insert at the near end, drop the near end, write at the far end.
  typedef struct packed {
    logic ins_near;
    logic del_near;
    logic wr_far;
  } row_ctl_t;

  // Per-cell command.
  typedef struct packed {
    logic take_near;
    logic take_far;
    logic load;
  } cell_ctl_t;

endpackage

/* hw/rtl/dequ_cell.sv */
// One storage cell of a deque row: holds one word, shifts toward either neighbor.
// Depends on dequ_pkg.
`timescale 1ns / 1ps
module dequ_cell #(
  parameter int unsigned DATA_WIDTH = dequ_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  dequ_pkg::cell_ctl_t   ctl_i,
  input  logic [DATA_WIDTH-1:0] near_word_i,
  input  logic [DATA_WIDTH-1:0] far_word_i,
  input  logic [DATA_WIDTH-1:0] load_word_i,
  output logic [DATA_WIDTH-1:0] word_o
);
  import dequ_pkg::*;

  logic [DATA_WIDTH-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.take_near) begin
      word_d = near_word_i;
    end else if (ctl_i.take_far) begin
      word_d = far_word_i;
    end else if (ctl_i.load) begin
      word_d = load_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

/* hw/rtl/dequ_row.sv */
// Row of deque cells; cell 0 is the near end, the far end is written by pointer.
// Depends on dequ_pkg and dequ_cell.
`timescale 1ns / 1ps
module dequ_row #(
  parameter int unsigned DEPTH      = dequ_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dequ_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  dequ_pkg::row_ctl_t    ctl_i,
  input  logic [AW-1:0]         wr_ptr_i,
  input  logic [DATA_WIDTH-1:0] push_word_i,
  output logic [DATA_WIDTH-1:0] near_word_o
);
  import dequ_pkg::*;

  logic [DATA_WIDTH-1:0] word [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t             cctl;
    logic [DATA_WIDTH-1:0] near_w;
    logic [DATA_WIDTH-1:0] far_w;

    assign cctl.take_near = ctl_i.ins_near;
    assign cctl.take_far  = ctl_i.del_near;
    assign cctl.load      = ctl_i.wr_far && (wr_ptr_i == AW'(i));

    if (i == 0) begin : g_first
      assign near_w = push_word_i;
    end else begin : g_mid
      assign near_w = word[i-1];
    end

    // Last cell holds on a near-end drop; its slot falls outside the count anyway.
    if (i == DEPTH - 1) begin : g_last
      assign far_w = word[i];
    end else begin : g_inner
      assign far_w = word[i+1];
    end

    dequ_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cctl),
      .near_word_i (near_w),
      .far_word_i  (far_w),
      .load_word_i (push_word_i),
      .word_o      (word[i])
    );
  end

  assign near_word_o = word[0];

endmodule

/* hw/rtl/dequ_ctrl.sv */
// Command decode, occupancy count and result register of the deque unit.
// Depends on dequ_pkg and double_ended_queue_unit_macros.svh.
`timescale 1ns / 1ps
`include "double_ended_queue_unit_macros.svh"
module dequ_ctrl #(
  parameter int unsigned DEPTH      = dequ_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dequ_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  dequ_pkg::in_word_t    cmd_i,
  input  logic [DATA_WIDTH-1:0] front_word_i,
  input  logic [DATA_WIDTH-1:0] back_word_i,
  output dequ_pkg::row_ctl_t    fwd_ctl_o,
  output dequ_pkg::row_ctl_t    rev_ctl_o,
  output logic [AW-1:0]         wr_ptr_o,
  output logic [DATA_WIDTH-1:0] push_word_o,
  output logic                  busy_o,
  output logic                  result_valid_o,
  output dequ_pkg::out_word_t   result_o
);
  import dequ_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] rd_word;
  logic signed [EW-1:0]  rd_ext;
  logic signed [EW-1:0]  push_ext;
  status_e               status;
  out_word_t             result_q, result_d;
  logic                  result_valid_q;
  logic                  busy_q;

  assign accept = start_i && !busy_q;
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);

  assign push_ext    = EW'(cmd_i.push_value);
  assign push_word_o = push_ext[DATA_WIDTH-1:0];
  assign wr_ptr_o    = count_q[AW-1:0];

  always_comb begin
    fwd_ctl_o = '0;
    rev_ctl_o = '0;
    count_d   = count_q;
    status    = ST_OK;
    rd_word   = '0;
    if (accept) begin
      case (cmd_i.func)
        FN_PUSH_FRONT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            fwd_ctl_o.ins_near = 1'b1;
            rev_ctl_o.wr_far   = 1'b1;
            count_d            = count_q + CW'(1);
          end
        end
        FN_PUSH_BACK: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            rev_ctl_o.ins_near = 1'b1;
            fwd_ctl_o.wr_far   = 1'b1;
            count_d            = count_q + CW'(1);
          end
        end
        FN_POP_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rd_word            = front_word_i;
            fwd_ctl_o.del_near = 1'b1;
            count_d            = count_q - CW'(1);
          end
        end
        FN_POP_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rd_word            = back_word_i;
            rev_ctl_o.del_near = 1'b1;
            count_d            = count_q - CW'(1);
          end
        end
        FN_PEEK_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rd_word = front_word_i;
          end
        end
        FN_PEEK_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rd_word = back_word_i;
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  assign rd_ext = EW'(signed'(rd_word));

  always_comb begin
    result_d.read_value  = rd_ext[VALUE_W-1:0];
    result_d.status      = status;
    result_d.entry_count = COUNT_W'(count_d);
    result_d.is_empty    = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      result_valid_q <= 1'b0;
      busy_q         <= 1'b1;
    end else begin
      count_q        <= count_d;
      result_valid_q <= accept;
      busy_q         <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign busy_o         = busy_q;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `DEQU_ASSERT(a_word_follows, clk_i, rst_ni, accept |=> result_valid_q)
  `DEQU_ASSERT(a_no_extra_word, clk_i, rst_ni, !accept |=> !result_valid_q)
  `DEQU_ASSERT(a_count_holds, clk_i, rst_ni, !accept |=> $stable(count_q))
  `DEQU_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `DEQU_ASSERT(a_full_at_depth, clk_i, rst_ni,
    (result_valid_q && result_q.status == ST_FULL) |-> (count_q == CW'(DEPTH)))
  // Any edge seen in reset has set busy by the next edge.
  `DEQU_ASSERT_ALWAYS(a_busy_in_reset, clk_i, !rst_ni |=> busy_q)

endmodule

/* hw/rtl/double_ended_queue_unit.sv */
// Top level of the double-ended queue unit.
// Depends on dequ_pkg, dequ_ctrl, dequ_row and dequ_cell.
`timescale 1ns / 1ps
// Double-ended queue of DEPTH signed words. A command (push front/back, pop
// front/back, peek front/back) is taken on a rising edge with start high and
// busy low; its result word appears on result_o in the next cycle,
// marked by result_valid_o for that single cycle, and must be captured then:
// there is no way to hold it. A new command may be issued every cycle, so the
// unit sustains one command per clock, with no stall between commands. The
// rate is set by the cell rows, which shift or load in one step, and by the
// occupancy counter, which moves by at most one per command. busy is high
// during reset and for the first cycle after it, then stays low. The words
// live in two rows of cells: one with the front in cell 0, one with the back
// in cell 0, so both ends are read at a fixed cell. A push shifts one row and
// loads the far-end cell of the other at the current count; a pop shifts one
// row and leaves the other to the count. There is no clearing pass after
// reset: cells beyond the count are never read. A push to a full queue is
// dropped with status full; a pop or peek on an empty queue gives status
// empty and read_value zero. Unused function codes do nothing and return ok.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH      = dequ_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dequ_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dequ_pkg::in_word_t  cmd_i,
  output logic                result_valid_o,
  output dequ_pkg::out_word_t result_o
);
  import dequ_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  row_ctl_t              fwd_ctl;
  row_ctl_t              rev_ctl;
  logic [AW-1:0]         wr_ptr;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] front_word;
  logic [DATA_WIDTH-1:0] back_word;

  // Decode, count and result register.
  dequ_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cmd_i          (cmd_i),
    .front_word_i   (front_word),
    .back_word_i    (back_word),
    .fwd_ctl_o      (fwd_ctl),
    .rev_ctl_o      (rev_ctl),
    .wr_ptr_o       (wr_ptr),
    .push_word_o    (push_word),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Front-ordered row: cell 0 holds the front word.
  dequ_row #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_fwd_row (
    .clk_i       (clk_i),
    .ctl_i       (fwd_ctl),
    .wr_ptr_i    (wr_ptr),
    .push_word_i (push_word),
    .near_word_o (front_word)
  );

  // Back-ordered row: cell 0 holds the back word.
  dequ_row #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_rev_row (
    .clk_i       (clk_i),
    .ctl_i       (rev_ctl),
    .wr_ptr_i    (wr_ptr),
    .push_word_i (push_word),
    .near_word_o (back_word)
  );

endmodule
